// File: rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg: binary to decimal ASCII shared definitions
// Digit count, place values, ASCII base and the digit extraction function.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

  localparam int unsigned NumDigits   = 5;
  localparam int unsigned MaxDigits   = 5;
  localparam int unsigned ValueWidth  = 16;
  localparam int unsigned WidthWidth  = 4;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned CharWidth   = 6;
  localparam int unsigned CountWidth  = 3;
  localparam int unsigned IdxWidth    = 3;
  localparam int unsigned SplitStages = NumDigits - 1;

  localparam logic [CharWidth-1:0] AsciiZero = CharWidth'(48);

  localparam logic [ValueWidth-1:0] Place [NumDigits] = '{
    ValueWidth'(10000), ValueWidth'(1000), ValueWidth'(100), ValueWidth'(10), ValueWidth'(1)
  };

  typedef logic [NumDigits-1:0][DigitWidth-1:0] digits_t;

  typedef struct packed {
    digits_t                 dig;
    logic [WidthWidth-1:0]   width;
  } split_t;

  // Largest k in 0..9 with k * place <= r.
  function automatic logic [DigitWidth-1:0] dec_digit(
    input logic [ValueWidth-1:0] r,
    input logic [ValueWidth-1:0] place
  );
    logic [DigitWidth-1:0] d;
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, r} >= (17'(k) * {1'b0, place})) begin
        d = DigitWidth'(k);
      end
    end
    return d;
  endfunction

  function automatic logic [ValueWidth-1:0] dec_rem(
    input logic [ValueWidth-1:0] r,
    input logic [DigitWidth-1:0] d,
    input logic [ValueWidth-1:0] place
  );
    return r - ValueWidth'({12'd0, d} * place);
  endfunction

endpackage

`default_nettype wire

// File: rtl/b2da_split.sv
// ----------------------------------------------------------------------------
// b2da_split: decimal digit extraction pipeline
// One register stage per place value from ten thousands down to tens; the last remainder is the units digit.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_split
  import b2da_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [ValueWidth-1:0] in_value_i,
  input  wire logic [WidthWidth-1:0] in_width_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      split_t                out_data_o
);

  logic [SplitStages-1:0]  valid_q;
  logic [SplitStages:0]    rdy;
  logic [ValueWidth-1:0]   rem_q [SplitStages];
  digits_t                 dig_q [SplitStages];
  logic [WidthWidth-1:0]   wid_q [SplitStages];

  assign rdy[SplitStages] = out_ready_i;
  assign in_ready_o       = rdy[0];

  for (genvar s = 0; s < SplitStages; s++) begin : g_stage
    logic                  vin;
    logic [ValueWidth-1:0] rin;
    digits_t               din;
    logic [WidthWidth-1:0] win;
    logic [DigitWidth-1:0] d;
    digits_t               dnext;

    if (s == 0) begin : g_first
      assign vin = in_valid_i;
      assign rin = in_value_i;
      assign din = '0;
      assign win = in_width_i;
    end else begin : g_next
      assign vin = valid_q[s-1];
      assign rin = rem_q[s-1];
      assign din = dig_q[s-1];
      assign win = wid_q[s-1];
    end

    assign rdy[s] = !valid_q[s] || rdy[s+1];
    assign d      = dec_digit(rin, Place[s]);

    always_comb begin
      dnext    = din;
      dnext[s] = d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && vin) begin
        rem_q[s] <= dec_rem(rin, d, Place[s]);
        dig_q[s] <= dnext;
        wid_q[s] <= win;
      end
    end
  end

  always_comb begin
    out_data_o.dig                = dig_q[SplitStages-1];
    out_data_o.dig[NumDigits-1]   = rem_q[SplitStages-1][DigitWidth-1:0];
    out_data_o.width              = wid_q[SplitStages-1];
  end

  assign out_valid_o = valid_q[SplitStages-1];

endmodule

`default_nettype wire

// File: rtl/b2da_format.sv
// ----------------------------------------------------------------------------
// b2da_format: character placement and output register
// Picks fixed or free width, aligns digits left and converts them to ASCII.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_format
  import b2da_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire split_t                in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [CharWidth-1:0]  out_char_o [NumDigits],
  output      logic [CountWidth-1:0] out_count_o
);

  logic                  valid_q;
  logic                  fixed;
  logic [IdxWidth-1:0]   first;
  logic [CountWidth-1:0] count;
  logic [CharWidth-1:0]  char_d [NumDigits];
  logic [CharWidth-1:0]  char_q [NumDigits];
  logic [CountWidth-1:0] count_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    logic [IdxWidth-1:0] idx;
    fixed = (in_data_i.width >= WidthWidth'(1)) && (in_data_i.width <= WidthWidth'(MaxDigits));
    if (fixed) begin
      first = IdxWidth'(NumDigits) - in_data_i.width[IdxWidth-1:0];
    end else if (in_data_i.dig[0] != '0) begin
      first = IdxWidth'(0);
    end else if (in_data_i.dig[1] != '0) begin
      first = IdxWidth'(1);
    end else if (in_data_i.dig[2] != '0) begin
      first = IdxWidth'(2);
    end else if (in_data_i.dig[3] != '0) begin
      first = IdxWidth'(3);
    end else begin
      first = IdxWidth'(4);
    end
    count = CountWidth'(NumDigits) - CountWidth'(first);
    for (int i = 0; i < NumDigits; i++) begin
      idx = first + IdxWidth'(i);
      if (CountWidth'(i) < count) begin
        char_d[i] = AsciiZero + CharWidth'(in_data_i.dig[idx]);
      end else begin
        char_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q  <= char_d;
      count_q <= count;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_count_o = count_q;

endmodule

`default_nettype wire

// File: rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: 16-bit binary to ASCII decimal converter
// Fixed zero-padded width 1..5, or free width without leading zeros.
// ----------------------------------------------------------------------------
// Takes one value per cycle while the output is not stalled and returns its
// decimal characters after four digit stages (one constant place value compare
// each, from ten thousands down to tens) followed by the formatting/output register.
// Backpressure on the master side stalls the pipeline without loss; bubbles
// collapse, so sustained throughput is one transfer per cycle.
`default_nettype none

module binary_to_decimal_ascii
  import b2da_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // value[15:0], width[19:16], zero pad
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [39:0] m_axis_tdata_o    // char_0..char_4 (6b each), char_count, pad
);

  logic                  mid_valid;
  logic                  mid_ready;
  split_t                mid_data;
  logic [CharWidth-1:0]  chars [NumDigits];
  logic [CountWidth-1:0] count;

  b2da_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_value_i  (s_axis_tdata_i[15:0]),
    .in_width_i  (s_axis_tdata_i[19:16]),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_data_o  (mid_data)
  );

  b2da_format u_format (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_data_i   (mid_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (chars),
    .out_count_o (count)
  );

  assign m_axis_tdata_o = {7'd0, count, chars[4], chars[3], chars[2], chars[1], chars[0]};

endmodule

`default_nettype wire

// File: rtl/b2da_checker.sv
// ----------------------------------------------------------------------------
// b2da_checker: port-level checks for binary_to_decimal_ascii
// Output hold under stall, input backpressure and character/count consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output transfer changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[32:30] >= 3'd1 && m_axis_tdata_o[32:30] <= 3'd5)
    else $error("character count out of range");

  a_first_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[5:0] >= 6'd48 && m_axis_tdata_o[5:0] <= 6'd57)
    else $error("leftmost character is not a digit");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[32:30] == 3'd1 |-> m_axis_tdata_o[29:6] == 24'd0)
    else $error("unused character positions not zero");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
